[design/gsqm_pkg.sv]
// shared types and constants for the golden-section quadratic minimum search
package gsqm_pkg;

  localparam int DATA_W = 32;               // Q-format operand width
  localparam int TOL_W = 31;                // tolerance width
  localparam int RND_OUT_W = 7;             // width of the reported round count
  localparam int MUL_W = 32;                // shared multiplier operand width
  localparam int PROD_W = 2 * MUL_W;        // shared multiplier product width
  localparam int VAL_W = 96;                // exact polynomial value width
  localparam int MAX_ROUNDS_DEF = 64;
  localparam int FRAC_BITS_DEF = 16;

  // 1/phi with 32 fraction bits, rounded
  localparam logic [MUL_W-1:0] INV_PHI = 32'd2654435769;

  // operand pair for the shared multiplier
  typedef struct packed {
    logic [MUL_W-1:0] op_a;
    logic [MUL_W-1:0] op_b;
  } mul_req_t;

endpackage

[design/gsqm_mul.sv]
// shared unsigned 32x32 multiplier with registered product
module gsqm_mul (
  input  logic                         clk,
  input  gsqm_pkg::mul_req_t           req,
  output logic [gsqm_pkg::PROD_W-1:0]  prod_r
);

  always_ff @(posedge clk) begin
    prod_r <= gsqm_pkg::PROD_W'(req.op_a) * gsqm_pkg::PROD_W'(req.op_b);
  end

endmodule

[design/golden_section_quadratic_min.sv]
// saturating floor shift of the exact polynomial value down to the output format
module gsqm_sat (
  input  logic signed [gsqm_pkg::VAL_W-1:0]  val,
  input  logic [5:0]                         shift,
  output logic signed [gsqm_pkg::DATA_W-1:0] res,
  output logic                               sat
);

  logic signed [gsqm_pkg::VAL_W-1:0] v;
  logic                              fits;

  // floor shift, then clip to the signed 32-bit range
  always_comb begin
    v = val >>> shift;
    fits = (v[gsqm_pkg::VAL_W-1:gsqm_pkg::DATA_W-1] == '0) ||
           (v[gsqm_pkg::VAL_W-1:gsqm_pkg::DATA_W-1] == '1);
    sat = !fits;
    if (fits) begin
      res = v[gsqm_pkg::DATA_W-1:0];
    end else if (v[gsqm_pkg::VAL_W-1]) begin
      res = {1'b1, {(gsqm_pkg::DATA_W-1){1'b0}}};
    end else begin
      res = {1'b0, {(gsqm_pkg::DATA_W-1){1'b1}}};
    end
  end

endmodule

[design/golden_section_quadratic_min_core.sv]
// top level: golden-section search for the minimum of a*x^2 + b*x + c
// A transfer on the input channel loads an interval [lower_end, upper_end] (either order) and
// the coefficients a, b, c, all signed fixed point with FRAC_BITS fraction bits, plus a
// tolerance. The block narrows the interval by golden-section rounds until its width is at
// most the tolerance or MAX_ROUNDS rounds have run, then returns the midpoint of the final
// interval, the polynomial value there (floor to FRAC_BITS fraction bits, clipped to 32
// bits with value_saturated set), the number of rounds and a converged flag. Polynomial
// values are formed exactly (Horner form, 96-bit) so the comparisons are exact; equal
// values move the lower end. All arithmetic goes through one registered 32x32 multiplier
// under a small sequencer. Each round runs the width check, the step product, the two
// polynomial evaluations and the compare; after the closing width check come the midpoint
// evaluation and the output step, and the idle state takes the transfer. Each evaluation
// makes three multiplier passes. One item is in flight at a time: in_ready is high only
// while the sequencer is idle. A finished result waits in the output register until its
// transfer and does not block the next input transfer; the sequencer only holds at its
// last step if the old result is still waiting.
module golden_section_quadratic_min_core #(
  parameter int MAX_ROUNDS = gsqm_pkg::MAX_ROUNDS_DEF,
  parameter int FRAC_BITS = gsqm_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // input channel
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [gsqm_pkg::DATA_W-1:0]  in_lower_end,
  input  logic signed [gsqm_pkg::DATA_W-1:0]  in_upper_end,
  input  logic signed [gsqm_pkg::DATA_W-1:0]  in_coef_quadratic,
  input  logic signed [gsqm_pkg::DATA_W-1:0]  in_coef_linear,
  input  logic signed [gsqm_pkg::DATA_W-1:0]  in_coef_constant,
  input  logic [gsqm_pkg::TOL_W-1:0]          in_tolerance,
  // result channel
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [gsqm_pkg::DATA_W-1:0]  out_argmin_point,
  output logic signed [gsqm_pkg::DATA_W-1:0]  out_min_value,
  output logic [gsqm_pkg::RND_OUT_W-1:0]      out_rounds_used,
  output logic                                out_converged,
  output logic                                out_value_saturated
);

  localparam int DW = gsqm_pkg::DATA_W;
  localparam int VW = gsqm_pkg::VAL_W;
  localparam int PW = gsqm_pkg::PROD_W;
  localparam int MW = gsqm_pkg::MUL_W;
  localparam int RND_W = $clog2(MAX_ROUNDS + 1);

  // sequencer states; E_* steps form one polynomial evaluation at x_r
  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_STEP,
    E_M1,
    E_H,
    E_ML,
    E_MH,
    E_SUM,
    E_FIN,
    S_CMP,
    S_OUT
  } state_t;

  // which point the running evaluation belongs to
  typedef enum logic [1:0] {
    PH_X1,
    PH_X2,
    PH_MID
  } phase_t;

  state_t state_r, state_nxt;
  phase_t phase_r, phase_nxt;

  // working interval and held item
  logic signed [DW-1:0]  s_r, s_nxt;
  logic signed [DW-1:0]  e_r, e_nxt;
  logic signed [DW-1:0]  a_r, a_nxt;
  logic signed [DW-1:0]  b_r, b_nxt;
  logic signed [DW-1:0]  c_r, c_nxt;
  logic [gsqm_pkg::TOL_W-1:0] tol_r, tol_nxt;
  logic [RND_W-1:0]      rnd_r, rnd_nxt;
  logic                  conv_r, conv_nxt;

  // round datapath
  logic                  d_neg_r, d_neg_nxt;
  logic signed [DW-1:0]  x_r, x_nxt;      // point under evaluation
  logic signed [DW-1:0]  x1_r, x1_nxt;
  logic signed [DW-1:0]  x2_r, x2_nxt;
  logic [PW-1:0]         h_mag_r, h_mag_nxt;
  logic                  h_neg_r, h_neg_nxt;
  logic [VW-1:0]         acc_r, acc_nxt;
  logic signed [VW-1:0]  f1_r, f1_nxt;
  logic signed [VW-1:0]  val_r, val_nxt;

  // output register
  logic                  out_valid_r, out_valid_nxt;
  logic signed [DW-1:0]  out_arg_r, out_arg_nxt;
  logic signed [DW-1:0]  out_val_r, out_val_nxt;
  logic [gsqm_pkg::RND_OUT_W-1:0] out_rnd_r, out_rnd_nxt;
  logic                  out_conv_r, out_conv_nxt;
  logic                  out_sat_r, out_sat_nxt;

  // shared multiplier
  gsqm_pkg::mul_req_t    mul_req;
  logic [PW-1:0]         prod_r;

  // combinational helpers
  logic signed [DW:0]    diff;
  logic [DW-1:0]         width;
  logic signed [DW:0]    mid_sum;
  logic [DW-1:0]         x_mag;
  logic [DW-1:0]         a_mag;
  logic [DW-1:0]         step;
  logic signed [PW-1:0]  ax_signed;
  logic signed [PW-1:0]  h_val;
  logic [VW-1:0]         mag_sum;
  logic signed [VW-1:0]  c_term;
  logic signed [DW-1:0]  sat_res;
  logic                  sat_flag;
  logic                  in_xfer;
  logic                  out_free;

  gsqm_mul u_mul (
    .clk    (clk),
    .req    (mul_req),
    .prod_r (prod_r)
  );

  gsqm_sat u_sat (
    .val   (val_r),
    .shift (6'(2 * FRAC_BITS)),
    .res   (sat_res),
    .sat   (sat_flag)
  );

  assign in_ready = (state_r == S_IDLE);
  assign in_xfer = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  assign out_valid = out_valid_r;
  assign out_argmin_point = out_arg_r;
  assign out_min_value = out_val_r;
  assign out_rounds_used = out_rnd_r;
  assign out_converged = out_conv_r;
  assign out_value_saturated = out_sat_r;

  // width, midpoint and magnitudes
  always_comb begin
    diff = {e_r[DW-1], e_r} - {s_r[DW-1], s_r};
    width = diff[DW] ? DW'(-diff) : diff[DW-1:0];
    mid_sum = {s_r[DW-1], s_r} + {e_r[DW-1], e_r};
    x_mag = x_r[DW-1] ? (~x_r + 1'b1) : x_r;
    a_mag = a_r[DW-1] ? (~a_r + 1'b1) : a_r;
    step = prod_r[PW-1:MW];
    // a*x signed from the magnitude product, then add b shifted to the x^1 scale
    ax_signed = (a_r[DW-1] ^ x_r[DW-1]) ? -$signed(prod_r) : $signed(prod_r);
    h_val = ax_signed + ($signed(PW'(b_r)) <<< FRAC_BITS);
    // high partial product lands 32 bits up
    mag_sum = acc_r + {prod_r, {MW{1'b0}}};
    c_term = $signed(VW'(c_r)) <<< (2 * FRAC_BITS);
  end

  // multiplier operand selection, product is registered and shows up in the next cycle
  always_comb begin
    mul_req = '0;
    case (state_r)
      S_CHECK: begin
        mul_req.op_a = width;
        mul_req.op_b = gsqm_pkg::INV_PHI;
      end
      E_M1: begin
        mul_req.op_a = a_mag;
        mul_req.op_b = x_mag;
      end
      E_ML: begin
        mul_req.op_a = h_mag_r[MW-1:0];
        mul_req.op_b = x_mag;
      end
      E_MH: begin
        mul_req.op_a = h_mag_r[PW-1:MW];
        mul_req.op_b = x_mag;
      end
      default: begin
        mul_req = '0;
      end
    endcase
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    s_nxt = s_r;
    e_nxt = e_r;
    a_nxt = a_r;
    b_nxt = b_r;
    c_nxt = c_r;
    tol_nxt = tol_r;
    rnd_nxt = rnd_r;
    conv_nxt = conv_r;
    d_neg_nxt = d_neg_r;
    x_nxt = x_r;
    x1_nxt = x1_r;
    x2_nxt = x2_r;
    h_mag_nxt = h_mag_r;
    h_neg_nxt = h_neg_r;
    acc_nxt = acc_r;
    f1_nxt = f1_r;
    val_nxt = val_r;
    out_valid_nxt = out_valid_r;
    out_arg_nxt = out_arg_r;
    out_val_nxt = out_val_r;
    out_rnd_nxt = out_rnd_r;
    out_conv_nxt = out_conv_r;
    out_sat_nxt = out_sat_r;

    // result transfer frees the output register
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          s_nxt = in_lower_end;
          e_nxt = in_upper_end;
          a_nxt = in_coef_quadratic;
          b_nxt = in_coef_linear;
          c_nxt = in_coef_constant;
          tol_nxt = in_tolerance;
          rnd_nxt = '0;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        // step product |d| * INV_PHI is issued here regardless
        d_neg_nxt = diff[DW];
        if (width <= DW'(tol_r) || rnd_r == RND_W'(MAX_ROUNDS)) begin
          conv_nxt = (width <= DW'(tol_r));
          x_nxt = mid_sum[DW:1];
          phase_nxt = PH_MID;
          state_nxt = E_M1;
        end else begin
          state_nxt = S_STEP;
        end
      end
      S_STEP: begin
        // interior points at 1/phi of the width from each end
        if (d_neg_r) begin
          x1_nxt = e_r + step;
          x2_nxt = s_r - step;
          x_nxt = e_r + step;
        end else begin
          x1_nxt = e_r - step;
          x2_nxt = s_r + step;
          x_nxt = e_r - step;
        end
        phase_nxt = PH_X1;
        state_nxt = E_M1;
      end
      E_M1: begin
        state_nxt = E_H;
      end
      E_H: begin
        // sign of h*x comes from both factors
        h_neg_nxt = h_val[PW-1] ^ x_r[DW-1];
        h_mag_nxt = h_val[PW-1] ? PW'(-h_val) : h_val;
        state_nxt = E_ML;
      end
      E_ML: begin
        state_nxt = E_MH;
      end
      E_MH: begin
        acc_nxt = VW'(prod_r);
        state_nxt = E_SUM;
      end
      E_SUM: begin
        acc_nxt = mag_sum;
        state_nxt = E_FIN;
      end
      E_FIN: begin
        val_nxt = (h_neg_r ? -$signed(acc_r) : $signed(acc_r)) + c_term;
        case (phase_r)
          PH_X1: begin
            f1_nxt = (h_neg_r ? -$signed(acc_r) : $signed(acc_r)) + c_term;
            x_nxt = x2_r;
            phase_nxt = PH_X2;
            state_nxt = E_M1;
          end
          PH_X2: begin
            state_nxt = S_CMP;
          end
          default: begin
            state_nxt = S_OUT;
          end
        endcase
      end
      S_CMP: begin
        // ties move the lower end
        if (!(f1_r < val_r)) begin
          s_nxt = x1_r;
        end else begin
          e_nxt = x2_r;
        end
        rnd_nxt = rnd_r + 1'b1;
        state_nxt = S_CHECK;
      end
      S_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_arg_nxt = x_r;
          out_val_nxt = sat_res;
          out_rnd_nxt = gsqm_pkg::RND_OUT_W'(rnd_r);
          out_conv_nxt = conv_r;
          out_sat_nxt = sat_flag;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state, datapath and output registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      phase_r <= PH_X1;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      out_valid_r <= out_valid_nxt;
    end
    s_r <= s_nxt;
    e_r <= e_nxt;
    a_r <= a_nxt;
    b_r <= b_nxt;
    c_r <= c_nxt;
    tol_r <= tol_nxt;
    rnd_r <= rnd_nxt;
    conv_r <= conv_nxt;
    d_neg_r <= d_neg_nxt;
    x_r <= x_nxt;
    x1_r <= x1_nxt;
    x2_r <= x2_nxt;
    h_mag_r <= h_mag_nxt;
    h_neg_r <= h_neg_nxt;
    acc_r <= acc_nxt;
    f1_r <= f1_nxt;
    val_r <= val_nxt;
    out_arg_r <= out_arg_nxt;
    out_val_r <= out_val_nxt;
    out_rnd_r <= out_rnd_nxt;
    out_conv_r <= out_conv_nxt;
    out_sat_r <= out_sat_nxt;
  end

endmodule

[verif/tb_golden_section_quadratic_min_core.sv]
// testbench for the golden-section quadratic minimum search core
`timescale 1ns / 100ps

module tb_golden_section_quadratic_min_core;

  localparam int W = gsqm_pkg::DATA_W;
  localparam int FRAC = gsqm_pkg::FRAC_BITS_DEF;
  localparam int ROUND_CAP = gsqm_pkg::MAX_ROUNDS_DEF;
  localparam int RANDOM_SEARCHES = 1500;
  localparam int LONG_HOLD_CYCLES = 4000;
  localparam int HOLD_AFTER_RESULTS = 300;
  localparam int DRAIN_CYCLES = 1000;     // a bit more than one 64-round search
  localparam int MAX_REPORTS = 40;

  // handy q16.16 values
  localparam logic [W-1:0] Q_ZERO = 32'h0000_0000;
  localparam logic [W-1:0] Q_ONE = 32'h0001_0000;
  localparam logic [W-1:0] Q_NEG_ONE = 32'hFFFF_0000;
  localparam logic [W-1:0] Q_FIVE = 32'h0005_0000;
  localparam logic [W-1:0] Q_NEG_SIX = 32'hFFFA_0000;
  localparam logic [W-1:0] Q_NINE = 32'h0009_0000;
  localparam logic [W-1:0] Q_TEN = 32'h000A_0000;
  localparam logic [W-1:0] Q_NEG_TEN = 32'hFFF6_0000;
  localparam logic [W-1:0] Q_HUNDRED = 32'h0064_0000;
  localparam logic [W-1:0] Q_NEG_HUNDRED = 32'hFF9C_0000;
  localparam logic [W-1:0] Q_MAX = 32'h7FFF_FFFF;
  localparam logic [W-1:0] Q_MIN = 32'h8000_0000;
  localparam logic [gsqm_pkg::TOL_W-1:0] TOL_MAX = 31'h7FFF_FFFF;

  // clip limits of the reported value, at the width of the exact polynomial
  localparam logic signed [127:0] VALUE_HI = 128'sd2147483647;
  localparam logic signed [127:0] VALUE_LO = -128'sd2147483648;

  // one search request as it crosses the input channel
  typedef struct packed {
    logic [W-1:0] lower_end;
    logic [W-1:0] upper_end;
    logic [W-1:0] coef_quadratic;
    logic [W-1:0] coef_linear;
    logic [W-1:0] coef_constant;
    logic [gsqm_pkg::TOL_W-1:0] tolerance;
  } search_t;

  // one result as it crosses the result channel
  typedef struct packed {
    logic [W-1:0] argmin_point;
    logic [W-1:0] min_value;
    logic [gsqm_pkg::RND_OUT_W-1:0] rounds_used;
    logic converged;
    logic value_saturated;
  } minimum_t;

  typedef struct packed {
    search_t search;
    logic typed;          // expected result written out below, not predicted
    minimum_t want;
  } directed_row_t;

  // receiver behaviors
  typedef enum int {
    SINK_OPEN,            // always ready
    SINK_COIN,            // ready half of the cycles
    SINK_SPARSE           // ready one cycle in eight
  } sink_mode_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic signed [W-1:0] in_lower_end;
  logic signed [W-1:0] in_upper_end;
  logic signed [W-1:0] in_coef_quadratic;
  logic signed [W-1:0] in_coef_linear;
  logic signed [W-1:0] in_coef_constant;
  logic [gsqm_pkg::TOL_W-1:0] in_tolerance;
  logic out_valid;
  logic out_ready;
  logic signed [W-1:0] out_argmin_point;
  logic signed [W-1:0] out_min_value;
  logic [gsqm_pkg::RND_OUT_W-1:0] out_rounds_used;
  logic out_converged;
  logic out_value_saturated;

  minimum_t expected_minima[$];
  int mismatches = 0;
  int results_seen = 0;
  int burst_left = 0;

  // directed searches: zero item, tiny intervals, clipping both ways, widest
  // intervals in both orders, flat and linear functions, tolerance extremes
  directed_row_t directed_rows [18] = '{
    // all zero: nothing to narrow
    '{'{Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, 31'd0}, 1'b1,
      '{Q_ZERO, Q_ZERO, 7'd0, 1'b1, 1'b0}},
    // width of one lsb collapses onto the upper end in a single round
    '{'{Q_ZERO, 32'd1, Q_ZERO, Q_ZERO, Q_ZERO, 31'd0}, 1'b1,
      '{32'd1, Q_ZERO, 7'd1, 1'b1, 1'b0}},
    // point interval at 1.0 with f = x^2
    '{'{Q_ONE, Q_ONE, Q_ONE, Q_ZERO, Q_ZERO, 31'd0}, 1'b1,
      '{Q_ONE, Q_ONE, 7'd0, 1'b1, 1'b0}},
    // huge positive value clips high
    '{'{Q_MIN, Q_MIN, Q_MAX, Q_ZERO, Q_ZERO, 31'd0}, 1'b1,
      '{Q_MIN, Q_MAX, 7'd0, 1'b1, 1'b1}},
    // huge negative value clips low
    '{'{Q_MIN, Q_MIN, Q_MIN, Q_ZERO, Q_ZERO, 31'd0}, 1'b1,
      '{Q_MIN, Q_MIN, 7'd0, 1'b1, 1'b1}},
    // most negative constant fits without clipping
    '{'{Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, Q_MIN, 31'd0}, 1'b1,
      '{Q_ZERO, Q_MIN, 7'd0, 1'b1, 1'b0}},
    // width equal to the largest tolerance: no rounds, midpoint floors to -1
    '{'{32'hC000_0000, 32'h3FFF_FFFF, Q_ZERO, Q_ZERO, Q_ZERO, TOL_MAX}, 1'b1,
      '{32'hFFFF_FFFF, Q_ZERO, 7'd0, 1'b1, 1'b0}},
    // widest interval, both orders, zero tolerance
    '{'{Q_MIN, Q_MAX, Q_ONE, Q_ZERO, Q_ZERO, 31'd0}, 1'b0, '0},
    '{'{Q_MAX, Q_MIN, Q_ONE, Q_ZERO, Q_ZERO, 31'd0}, 1'b0, '0},
    // extreme coefficients over the widest interval
    '{'{Q_MIN, Q_MAX, Q_MAX, Q_MAX, Q_MAX, 31'd0}, 1'b0, '0},
    '{'{Q_MIN, Q_MAX, Q_MIN, Q_MIN, Q_MIN, 31'd0}, 1'b0, '0},
    // flat function: every compare ties, lower end keeps moving
    '{'{Q_NEG_TEN, Q_TEN, Q_ZERO, Q_ZERO, Q_FIVE, 31'd0}, 1'b0, '0},
    // linear slope, stop at 1.0 width
    '{'{Q_NEG_HUNDRED, Q_HUNDRED, Q_ZERO, Q_ONE, Q_ZERO, 31'h0001_0000}, 1'b0, '0},
    // (x - 3)^2 on [0, 10], both orders
    '{'{Q_ZERO, Q_TEN, Q_ONE, Q_NEG_SIX, Q_NINE, 31'd1}, 1'b0, '0},
    '{'{Q_TEN, Q_ZERO, Q_ONE, Q_NEG_SIX, Q_NINE, 31'd1}, 1'b0, '0},
    // one lsb interval given upside down
    '{'{32'd1, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, 31'd0}, 1'b0, '0},
    // widest interval against the largest tolerance
    '{'{Q_MIN, Q_MAX, Q_ONE, Q_MIN, Q_MAX, TOL_MAX}, 1'b0, '0},
    // steep mixed-sign polynomial on [-1, 1]
    '{'{Q_NEG_ONE, Q_ONE, Q_MAX, Q_MIN, Q_MAX, 31'd0}, 1'b0, '0}
  };

  golden_section_quadratic_min_core u_top (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_lower_end        (in_lower_end),
    .in_upper_end        (in_upper_end),
    .in_coef_quadratic   (in_coef_quadratic),
    .in_coef_linear      (in_coef_linear),
    .in_coef_constant    (in_coef_constant),
    .in_tolerance        (in_tolerance),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_argmin_point    (out_argmin_point),
    .out_min_value       (out_min_value),
    .out_rounds_used     (out_rounds_used),
    .out_converged       (out_converged),
    .out_value_saturated (out_value_saturated)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // exact a*x^2 + (b*x << F) + (c << 2F), 3F fraction bits
  function automatic logic signed [127:0] poly_exact(input search_t s, input longint x);
    logic signed [127:0] qa, qb, qc, qx;
    qa = $signed(s.coef_quadratic);
    qb = $signed(s.coef_linear);
    qc = $signed(s.coef_constant);
    qx = x;
    return qa * qx * qx + ((qb * qx) <<< FRAC) + (qc <<< (2 * FRAC));
  endfunction

  // full golden-section search on one request
  function automatic minimum_t golden_search(input search_t s);
    longint lo_end, hi_end, span, step, x1, x2, width, tol, mid;
    logic [63:0] span_mag, step_prod;
    logic signed [127:0] value;
    int rounds;
    minimum_t r;
    lo_end = longint'($signed(s.lower_end));
    hi_end = longint'($signed(s.upper_end));
    tol = longint'(s.tolerance);
    rounds = 0;
    width = (hi_end >= lo_end) ? hi_end - lo_end : lo_end - hi_end;
    while (width > tol && rounds < ROUND_CAP) begin
      span = hi_end - lo_end;
      span_mag = (span < 0) ? -span : span;
      // step = floor(|span| / phi) with 1/phi held to 32 fraction bits
      step_prod = span_mag * {32'd0, gsqm_pkg::INV_PHI};
      step = longint'(step_prod >> 32);
      x1 = (span >= 0) ? hi_end - step : hi_end + step;
      x2 = (span >= 0) ? lo_end + step : lo_end - step;
      // ties move the first end in
      if (poly_exact(s, x1) >= poly_exact(s, x2)) begin
        lo_end = x1;
      end else begin
        hi_end = x2;
      end
      rounds++;
      width = (hi_end >= lo_end) ? hi_end - lo_end : lo_end - hi_end;
    end
    mid = (lo_end + hi_end) >>> 1;       // floor of the mean
    value = poly_exact(s, mid) >>> (2 * FRAC);
    r.argmin_point = mid[W-1:0];
    r.rounds_used = rounds[gsqm_pkg::RND_OUT_W-1:0];
    r.converged = (width <= tol);
    r.value_saturated = (value > VALUE_HI) || (value < VALUE_LO);
    if (value > VALUE_HI) begin
      r.min_value = Q_MAX;
    end else if (value < VALUE_LO) begin
      r.min_value = Q_MIN;
    end else begin
      r.min_value = value[W-1:0];
    end
    return r;
  endfunction

  // coefficient of random magnitude, full-range a third of the time
  function automatic logic [W-1:0] rand_coef();
    int unsigned bits;
    bits = $urandom_range(1, 32);
    if ($urandom_range(0, 2) == 0) begin
      return $urandom;
    end
    return $signed($urandom) >>> (32 - bits);
  endfunction

  // random request: mostly narrow intervals so the rounds stay moderate,
  // some full-range ends, either order
  function automatic search_t random_search();
    search_t s;
    longint lo_end, hi_end, w;
    lo_end = longint'($signed($urandom));
    if ($urandom_range(0, 4) == 0) begin
      hi_end = longint'($signed($urandom));
    end else begin
      w = longint'($urandom >> $urandom_range(0, 31));
      hi_end = lo_end + w;
      if (hi_end > 64'sd2147483647) begin
        hi_end = lo_end - w;
      end
      if (hi_end < -64'sd2147483648) begin
        hi_end = -64'sd2147483648;
      end
    end
    if ($urandom_range(0, 1) == 1) begin
      s.lower_end = lo_end[W-1:0];
      s.upper_end = hi_end[W-1:0];
    end else begin
      s.lower_end = hi_end[W-1:0];
      s.upper_end = lo_end[W-1:0];
    end
    s.coef_quadratic = rand_coef();
    s.coef_linear = rand_coef();
    s.coef_constant = rand_coef();
    case ($urandom_range(0, 7))
      0, 1: s.tolerance = '0;
      2: s.tolerance = gsqm_pkg::TOL_W'($urandom);
      default: s.tolerance = gsqm_pkg::TOL_W'($urandom >> $urandom_range(1, 31));
    endcase
    return s;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    mismatches++;
    if (mismatches <= MAX_REPORTS) begin
      $display("result %0d: %s got %0d expected %0d", results_seen, what, got, want);
    end
  endtask

  // offer one request at the current falling edge, hold it until the transfer,
  // then leave valid up for the next burst item or drop it for a gap
  task automatic transfer_search(input search_t s, input logic typed, input minimum_t want,
                                 input bit last);
    int gap;
    in_valid <= 1'b1;
    in_lower_end <= s.lower_end;
    in_upper_end <= s.upper_end;
    in_coef_quadratic <= s.coef_quadratic;
    in_coef_linear <= s.coef_linear;
    in_coef_constant <= s.coef_constant;
    in_tolerance <= s.tolerance;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_minima.push_back(typed ? want : golden_search(s));
    @(negedge clk);
    gap = 0;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 15);
      // now and then a gap long enough to find the core idle
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 1200) : $urandom_range(1, 40);
    end
    if (last || gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // stimulus: reset, directed table, random requests, then drain
  initial begin : stimulus
    in_valid = 1'b0;
    in_lower_end = '0;
    in_upper_end = '0;
    in_coef_quadratic = '0;
    in_coef_linear = '0;
    in_coef_constant = '0;
    in_tolerance = '0;
    rst_n = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    foreach (directed_rows[i]) begin
      transfer_search(directed_rows[i].search, directed_rows[i].typed,
                      directed_rows[i].want, 1'b0);
    end
    for (int n = 0; n < RANDOM_SEARCHES; n++) begin
      transfer_search(random_search(), 1'b0, '0, n == RANDOM_SEARCHES - 1);
    end
    // wait for every outstanding result, then watch for strays
    while (expected_minima.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // receiver: switches between its stall modes, and once holds off for a
  // long stretch so the output register fills and the input side backs up
  initial begin : result_sink
    sink_mode_t mode;
    int mode_left;
    int hold_left;
    bit held_once;
    out_ready = 1'b0;
    mode = SINK_OPEN;
    mode_left = 0;
    hold_left = 0;
    held_once = 1'b0;
    forever begin
      @(negedge clk);
      if (!held_once && results_seen >= HOLD_AFTER_RESULTS) begin
        held_once = 1'b1;
        hold_left = LONG_HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode = sink_mode_t'($urandom_range(0, 2));
          mode_left = $urandom_range(20, 400);
        end
        mode_left--;
        case (mode)
          SINK_OPEN: out_ready <= 1'b1;
          SINK_COIN: out_ready <= ($urandom_range(0, 1) == 1);
          default: out_ready <= ($urandom_range(0, 7) == 0);
        endcase
      end
    end
  end

  // result checker: each result transfer against the oldest expectation
  always @(posedge clk) begin : result_check
    minimum_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_minima.size() == 0) begin
        report_mismatch("unexpected result, argmin_point", out_argmin_point, 0);
      end else begin
        want = expected_minima.pop_front();
        if (out_argmin_point !== want.argmin_point) begin
          report_mismatch("argmin_point", out_argmin_point, $signed(want.argmin_point));
        end
        if (out_min_value !== want.min_value) begin
          report_mismatch("min_value", out_min_value, $signed(want.min_value));
        end
        if (out_rounds_used !== want.rounds_used) begin
          report_mismatch("rounds_used", out_rounds_used, want.rounds_used);
        end
        if (out_converged !== want.converged) begin
          report_mismatch("converged", out_converged, want.converged);
        end
        if (out_value_saturated !== want.value_saturated) begin
          report_mismatch("value_saturated", out_value_saturated, want.value_saturated);
        end
      end
      results_seen++;
    end
  end

  // hard stop well past the slowest legal run
  initial begin : watchdog
    #40_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

[filelist.f]
design/gsqm_pkg.sv
design/gsqm_mul.sv
design/golden_section_quadratic_min.sv
design/golden_section_quadratic_min_core.sv
verif/tb_golden_section_quadratic_min_core.sv
